// ===== rtl/core/mbps_pkg.sv =====
`default_nettype none

package mbps_pkg;

  // Longest pattern and offset width of the scan
  localparam int MAX_PATTERN = 16;
  localparam int OFFSET_BITS = 32;

  // Pattern bytes that the configuration registers can hold
  localparam int PAT_BYTES = 16;

  localparam int HIST_DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
  localparam int LEN_W      = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 3'd0,
    CFG_PATTERN_HIGH   = 3'd1,
    CFG_CARE_MASK      = 3'd2,
    CFG_PATTERN_LENGTH = 3'd3,
    CFG_SCAN_START     = 3'd4,
    CFG_SCAN_LIMIT     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]             data_byte;
    logic [OFFSET_BITS-1:0] byte_offset;
    logic                   region_first;
    logic                   new_scan;
  } in_t;

  typedef struct packed {
    logic                   match_hit;
    logic [OFFSET_BITS-1:0] match_offset;
    logic                   already_found;
  } out_t;

  typedef struct packed {
    logic [63:0]            pattern_low;
    logic [63:0]            pattern_high;
    logic [PAT_BYTES-1:0]   care_mask;
    logic [4:0]             pattern_length;
    logic [OFFSET_BITS-1:0] scan_start;
    logic [OFFSET_BITS-1:0] scan_limit;
  } cfg_t;

  // One classified byte on its way from the front to the back
  typedef struct packed {
    logic                   candidate;
    logic                   new_scan;
    logic [OFFSET_BITS-1:0] match_start;
  } cand_t;

endpackage

`default_nettype wire

// ===== rtl/core/masked_byte_pattern_search_core.sv =====
// Masked byte signature scan.
// Input channel (in_valid_i / in_ready_o / in_data_i): one beat per scanned byte,
// with its offset, a region-start flag and a new-scan flag. Output channel
// (out_valid_o / out_ready_i / out_data_o): exactly one beat per input beat, in
// order, telling whether this byte completes the first match of the scan.
// Configuration: write cfg_we_i with a register index and data; registers are
// pattern low/high, care mask, pattern length, scan start and scan limit.
// Write them only while no beat is in flight.
// With no stall, a taken input beat is written into the queue, then popped into
// the output register behind out_valid_o. Sustained throughput is one byte per
// cycle while out_ready_i stays high: the front compares the whole window in
// parallel and the back resolves the first-match flag in one step. The front and
// back are split by a four-entry queue; when the receiver stalls, the output
// register holds, the queue fills, and in_ready_o drops only once it is full.
// Reset clears the window fill count, the found flag, the queue and the output
// valid, and loads the register defaults (care mask all ones, length one,
// full scan range).
`default_nettype none

module masked_byte_pattern_search_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [mbps_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire mbps_pkg::in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output mbps_pkg::out_t                       out_data_o
);

  localparam int OfsW = mbps_pkg::OFFSET_BITS;

  mbps_pkg::cfg_t  cfg_q;
  logic            push, q_full, pop, q_empty;
  mbps_pkg::cand_t push_data, pop_data;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_low    <= '0;
      cfg_q.pattern_high   <= '0;
      cfg_q.care_mask      <= '1;
      cfg_q.pattern_length <= 5'd1;
      cfg_q.scan_start     <= '0;
      cfg_q.scan_limit     <= '1;
    end else if (cfg_we_i) begin
      case (mbps_pkg::cfg_reg_e'(cfg_index_i))
        mbps_pkg::CFG_PATTERN_LOW:    cfg_q.pattern_low    <= cfg_wdata_i[63:0];
        mbps_pkg::CFG_PATTERN_HIGH:   cfg_q.pattern_high   <= cfg_wdata_i[63:0];
        mbps_pkg::CFG_CARE_MASK:
          cfg_q.care_mask <= cfg_wdata_i[mbps_pkg::PAT_BYTES-1:0];
        mbps_pkg::CFG_PATTERN_LENGTH: cfg_q.pattern_length <= cfg_wdata_i[4:0];
        mbps_pkg::CFG_SCAN_START:     cfg_q.scan_start     <= cfg_wdata_i[OfsW-1:0];
        mbps_pkg::CFG_SCAN_LIMIT:     cfg_q.scan_limit     <= cfg_wdata_i[OfsW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: take a byte, advance the window, classify the candidate match
  mbps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  mbps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_data)
  );

  // Back: check the scan range, keep only the first match, drive the result beat
  mbps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/mbps_front.sv =====
`default_nettype none

module mbps_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mbps_pkg::cfg_t cfg_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire mbps_pkg::in_t  in_data_i,
  input  wire logic           q_full_i,
  output logic                push_o,
  output mbps_pkg::cand_t     push_data_o
);

  localparam int MaxPat = mbps_pkg::MAX_PATTERN;
  localparam int LenW   = mbps_pkg::LEN_W;
  localparam int IdxW   = mbps_pkg::IDX_W;
  localparam int OfsW   = mbps_pkg::OFFSET_BITS;

  logic [7:0]             hist_q [mbps_pkg::HIST_DEPTH];
  logic [LenW-1:0]        fill_q, fill_d, fill_cur;
  logic [LenW-1:0]        len, len_m1;
  logic [7:0]             win [MaxPat];
  logic [MaxPat-1:0]      byte_ok;
  logic [8*mbps_pkg::PAT_BYTES-1:0] pat_all;
  logic                   fill_ok, offs_ok, accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;
  assign pat_all    = {cfg_i.pattern_high, cfg_i.pattern_low};

  // Clamp the length register into 1..MAX_PATTERN
  always_comb begin
    if (cfg_i.pattern_length == '0) begin
      len = LenW'(1);
    end else if (int'(cfg_i.pattern_length) > MaxPat) begin
      len = LenW'(MaxPat);
    end else begin
      len = LenW'(cfg_i.pattern_length);
    end
  end
  assign len_m1 = len - LenW'(1);

  // Region start or new scan empties the window before this byte
  assign fill_cur = (in_data_i.new_scan || in_data_i.region_first) ? '0 : fill_q;

  // Window newest first: the current byte, then the history
  always_comb begin
    win[0] = in_data_i.data_byte;
    for (int k = 1; k < MaxPat; k++) begin
      win[k] = hist_q[k-1];
    end
  end

  for (genvar i = 0; i < MaxPat; i++) begin : g_cmp
    if (i < mbps_pkg::PAT_BYTES) begin : g_cared
      logic [LenW-1:0] pos;
      assign pos        = len_m1 - LenW'(i);
      assign byte_ok[i] = (LenW'(i) >= len) || !cfg_i.care_mask[i] ||
                          (win[pos[IdxW-1:0]] == pat_all[8*i +: 8]);
    end else begin : g_wild
      assign byte_ok[i] = 1'b1;
    end
  end

  assign fill_ok = (fill_cur + LenW'(1)) >= len;
  assign offs_ok = in_data_i.byte_offset >= OfsW'(len_m1);

  assign push_data_o.candidate   = (&byte_ok) && fill_ok && offs_ok;
  assign push_data_o.new_scan    = in_data_i.new_scan;
  assign push_data_o.match_start = in_data_i.byte_offset - OfsW'(len_m1);

  // Saturate the fill count at the history depth
  assign fill_d = (fill_cur == LenW'(MaxPat - 1)) ? fill_cur : fill_cur + LenW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (accept) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hist_q[0] <= in_data_i.data_byte;
      for (int k = 1; k < mbps_pkg::HIST_DEPTH; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mbps_queue.sv =====
`default_nettype none

module mbps_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire mbps_pkg::cand_t push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output mbps_pkg::cand_t      pop_data_o
);

  localparam int Depth = mbps_pkg::QUEUE_DEPTH;
  localparam int PtrW  = mbps_pkg::QPTR_W;

  mbps_pkg::cand_t  entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    count_q;

  assign full_o     = count_q == (PtrW + 1)'(Depth);
  assign empty_o    = count_q == '0;
  assign pop_data_o = entry_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
    next_ptr = (ptr == PtrW'(Depth - 1)) ? '0 : ptr + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (PtrW + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (PtrW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mbps_back.sv =====
`default_nettype none

module mbps_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mbps_pkg::cfg_t  cfg_i,
  input  wire logic            q_empty_i,
  input  wire mbps_pkg::cand_t q_data_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output mbps_pkg::out_t       out_data_o
);

  logic           out_valid_q;
  logic           found_q, found_d;
  logic           prior, hit, in_range;
  mbps_pkg::out_t out_data_q, out_data_d;

  assign pop_o = !q_empty_i && (!out_valid_q || out_ready_i);

  assign in_range = (q_data_i.match_start >= cfg_i.scan_start) &&
                    (q_data_i.match_start <  cfg_i.scan_limit);
  assign prior    = q_data_i.new_scan ? 1'b0 : found_q;
  assign hit      = !prior && q_data_i.candidate && in_range;
  assign found_d  = prior || hit;

  assign out_data_d.match_hit     = hit;
  assign out_data_d.match_offset  = hit ? q_data_i.match_start : '0;
  assign out_data_d.already_found = prior;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        found_q     <= found_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
